>>> sv/dhwp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhwp_pkg
// Shared constants, codes and types of the double hash word probe.
// ----------------------------------------------------------------------------
package dhwp_pkg;

    localparam int MAX_BUCKETS    = 1024;
    localparam int MAX_WORD_BYTES = 64;

    localparam int SLOT_W = $clog2(MAX_BUCKETS);
    localparam int POS_W  = $clog2(MAX_WORD_BYTES);
    localparam int LEN_W  = POS_W + 1;
    localparam int CNT_W  = SLOT_W + 1;
    localparam int HASH_W = 32;
    localparam int DIV_W  = $clog2(HASH_W);

    localparam logic [1:0] MODE_WORD  = 2'd0;
    localparam logic [1:0] MODE_USED  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [1:0] STATUS_EMPTY = 2'd0;
    localparam logic [1:0] STATUS_MATCH = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_UREAD = 8'b0000_1000,
        ST_UCHK  = 8'b0001_0000,
        ST_WREAD = 8'b0010_0000,
        ST_WCHK  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } t_state;

endpackage
`default_nettype wire

>>> sv/double_hash_word_probe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_word_probe
// Word-keyed open addressing hash table probe with double hashing.
// ----------------------------------------------------------------------------
// Load words (stored bytes, used flags) and query bytes are accepted only in
// the idle state. The last query byte starts a restoring divider for both
// k mod n and k mod (n-1), then a probe that per slot visited reads the used
// flag and per stored byte compared reads the word memory and the query
// buffer, then the done state posts the result once the output is free.
// After reset the used flags are cleared one per cycle, with no word accepted
// until all 1024 are clear. Configuration writes are taken in any cycle.
module double_hash_word_probe (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [10:0]                i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [dhwp_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [dhwp_pkg::POS_W-1:0] i_position,
    input  wire logic [7:0]                 i_byte_value,
    input  wire logic                       i_used_value,
    input  wire logic                       i_last,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_status,
    output logic [dhwp_pkg::SLOT_W-1:0]     o_result_slot
);

    localparam int SW = dhwp_pkg::SLOT_W;
    localparam int PW = dhwp_pkg::POS_W;
    localparam int LW = dhwp_pkg::LEN_W;
    localparam int CW = dhwp_pkg::CNT_W;
    localparam int HW = dhwp_pkg::HASH_W;
    localparam int DW = dhwp_pkg::DIV_W;

    logic [7:0]    word_mem [dhwp_pkg::MAX_BUCKETS*dhwp_pkg::MAX_WORD_BYTES];
    logic          used_mem [dhwp_pkg::MAX_BUCKETS];
    logic [7:0]    qbuf_mem [dhwp_pkg::MAX_WORD_BYTES];

    dhwp_pkg::t_state r_state;
    logic [10:0]   r_bucket_count;
    logic [SW-1:0] r_clr;
    logic [HW-1:0] r_k;
    logic [LW-1:0] r_qlen;
    logic [HW-1:0] r_dq;
    logic [DW-1:0] r_dcnt;
    logic [CW-1:0] r_rem1, r_rem2;
    logic [SW-1:0] r_h, r_step;
    logic [CW-1:0] r_i;
    logic [PW-1:0] r_j;
    logic          r_used_q;
    logic [7:0]    r_wd_q, r_qb_q;
    logic [1:0]    r_res_status;
    logic [SW-1:0] r_res_slot;
    logic          r_out_valid;
    logic [1:0]    r_status;
    logic [SW-1:0] r_out_slot;

    logic          w_acc;
    logic [CW-1:0] w_n, w_nm1;
    logic [HW-1:0] w_c, n_k;
    logic [CW-1:0] w_s1, w_s2, n_rem1, n_rem2;
    logic [CW-1:0] w_hsum;
    logic [SW-1:0] n_h;
    logic [CW-1:0] n_i;
    logic [7:0]    w_q;

    assign o_in_ready    = (r_state == dhwp_pkg::ST_IDLE);
    assign w_acc         = i_in_valid && o_in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_result_slot = r_out_slot;

    always_comb begin
        if (r_bucket_count < 11'd2) begin
            w_n = CW'(2);
        end else if (r_bucket_count > 11'(dhwp_pkg::MAX_BUCKETS)) begin
            w_n = CW'(dhwp_pkg::MAX_BUCKETS);
        end else begin
            w_n = CW'(r_bucket_count);
        end
    end
    assign w_nm1 = w_n - CW'(1);

    assign w_c = {{(HW-8){i_byte_value[7]}}, i_byte_value};
    assign n_k = (r_k << 5) + r_k + w_c;

    // one quotient bit per cycle for both moduli
    assign w_s1   = {r_rem1[CW-2:0], r_dq[HW-1]};
    assign w_s2   = {r_rem2[CW-2:0], r_dq[HW-1]};
    assign n_rem1 = (w_s1 >= w_n)   ? w_s1 - w_n   : w_s1;
    assign n_rem2 = (w_s2 >= w_nm1) ? w_s2 - w_nm1 : w_s2;

    assign w_hsum = {1'b0, r_h} + {1'b0, r_step};
    assign n_h    = (w_hsum >= w_n) ? SW'(w_hsum - w_n) : SW'(w_hsum);
    assign n_i    = r_i + CW'(1);

    assign w_q = ({1'b0, r_j} < r_qlen) ? r_qb_q : 8'd0;

    // memories
    always_ff @(posedge i_clk) begin
        if (r_state == dhwp_pkg::ST_CLEAR) begin
            used_mem[r_clr] <= 1'b0;
        end else if (w_acc && i_mode == dhwp_pkg::MODE_USED) begin
            used_mem[i_slot] <= i_used_value;
        end
        r_used_q <= used_mem[r_h];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_mode == dhwp_pkg::MODE_WORD) begin
            word_mem[{i_slot, i_position}] <= i_byte_value;
        end
        r_wd_q <= word_mem[{r_h, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_mode == dhwp_pkg::MODE_QUERY && i_byte_value != 8'd0
            && r_qlen < LW'(dhwp_pkg::MAX_WORD_BYTES)) begin
            qbuf_mem[r_qlen[PW-1:0]] <= i_byte_value;
        end
        r_qb_q <= qbuf_mem[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= 11'(dhwp_pkg::MAX_BUCKETS);
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dhwp_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_k         <= '0;
            r_qlen      <= '0;
            r_out_valid <= 1'b0;
            r_dcnt      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_h         <= '0;
        end else begin
            // the done state posts its own word
            if (r_out_valid && i_out_ready && r_state != dhwp_pkg::ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                dhwp_pkg::ST_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(dhwp_pkg::MAX_BUCKETS - 1)) begin
                        r_state <= dhwp_pkg::ST_IDLE;
                    end
                end
                dhwp_pkg::ST_IDLE: begin
                    if (w_acc && i_mode == dhwp_pkg::MODE_QUERY) begin
                        logic [HW-1:0] v_k;
                        v_k = r_k;
                        if (i_byte_value != 8'd0) begin
                            v_k = n_k;
                            if (r_qlen <= LW'(dhwp_pkg::MAX_WORD_BYTES)) begin
                                r_qlen <= r_qlen + LW'(1);
                            end
                        end
                        r_k <= v_k;
                        if (i_last) begin
                            r_dq    <= v_k;
                            r_rem1  <= '0;
                            r_rem2  <= '0;
                            r_dcnt  <= '0;
                            r_state <= dhwp_pkg::ST_DIV;
                        end
                    end
                end
                dhwp_pkg::ST_DIV: begin
                    r_rem1 <= n_rem1;
                    r_rem2 <= n_rem2;
                    r_dq   <= r_dq << 1;
                    r_dcnt <= r_dcnt + DW'(1);
                    if (r_dcnt == DW'(HW - 1)) begin
                        r_h     <= SW'(n_rem1);
                        r_step  <= SW'(n_rem2 + CW'(1));
                        r_i     <= '0;
                        r_state <= dhwp_pkg::ST_UREAD;
                    end
                end
                dhwp_pkg::ST_UREAD: begin
                    r_state <= dhwp_pkg::ST_UCHK;
                end
                dhwp_pkg::ST_UCHK: begin
                    if (!r_used_q) begin
                        r_res_status <= dhwp_pkg::STATUS_EMPTY;
                        r_res_slot   <= r_h;
                        r_state      <= dhwp_pkg::ST_DONE;
                    end else begin
                        r_j     <= '0;
                        r_state <= dhwp_pkg::ST_WREAD;
                    end
                end
                dhwp_pkg::ST_WREAD: begin
                    r_state <= dhwp_pkg::ST_WCHK;
                end
                dhwp_pkg::ST_WCHK: begin
                    logic v_adv;
                    v_adv = 1'b0;
                    if (r_wd_q != w_q) begin
                        v_adv = 1'b1;
                    end else if (r_wd_q == 8'd0) begin
                        r_res_status <= dhwp_pkg::STATUS_MATCH;
                        r_res_slot   <= r_h;
                        r_state      <= dhwp_pkg::ST_DONE;
                    end else if (r_j == PW'(dhwp_pkg::MAX_WORD_BYTES - 1)) begin
                        if (r_qlen == LW'(dhwp_pkg::MAX_WORD_BYTES)) begin
                            r_res_status <= dhwp_pkg::STATUS_MATCH;
                            r_res_slot   <= r_h;
                            r_state      <= dhwp_pkg::ST_DONE;
                        end else begin
                            v_adv = 1'b1;
                        end
                    end else begin
                        r_j     <= r_j + PW'(1);
                        r_state <= dhwp_pkg::ST_WREAD;
                    end
                    // advance to the next slot, or give up after n probes
                    if (v_adv) begin
                        r_i <= n_i;
                        if (n_i == w_n) begin
                            r_res_status <= dhwp_pkg::STATUS_FULL;
                            r_res_slot   <= '0;
                            r_state      <= dhwp_pkg::ST_DONE;
                        end else begin
                            r_h     <= n_h;
                            r_state <= dhwp_pkg::ST_UREAD;
                        end
                    end
                end
                dhwp_pkg::ST_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_res_status;
                        r_out_slot  <= r_res_slot;
                        r_k         <= '0;
                        r_qlen      <= '0;
                        r_state     <= dhwp_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= dhwp_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/dhwp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dhwp_checker
// Port-level checks of the double hash word probe.
// ----------------------------------------------------------------------------
module dhwp_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_in_ready,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [1:0]                  o_status,
    input wire logic [dhwp_pkg::SLOT_W-1:0] o_result_slot
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_result_slot))
        else $error("result word changed while stalled");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == dhwp_pkg::STATUS_EMPTY
            || o_status == dhwp_pkg::STATUS_MATCH
            || o_status == dhwp_pkg::STATUS_FULL))
        else $error("bad status code");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == dhwp_pkg::STATUS_FULL |-> o_result_slot == '0)
        else $error("full status with nonzero slot");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_in_ready && !o_out_valid)
        else $error("busy flag clear pass skipped");

endmodule

bind double_hash_word_probe dhwp_checker u_dhwp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_result_slot (o_result_slot)
);
`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_hash_word_probe. A local model of the table
// (stored words, used flags, query hash and buffer) predicts the probe result
// of every accepted query word. Results are checked in order against it.
// Directed cases cover the extremes and corner cases. Random phases follow
// under several bucket counts, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SW = dhwp_pkg::SLOT_W;
    localparam int PW = dhwp_pkg::POS_W;
    localparam int NB = dhwp_pkg::MAX_BUCKETS;
    localparam int WB = dhwp_pkg::MAX_WORD_BYTES;
    localparam logic [1:0] MODE_NONE = 2'd3;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int ITEM_TARGET  = 1150;
    localparam int SETTLE       = 40;

    typedef struct packed {
        logic [1:0]    status;
        logic [SW-1:0] slot;
    } t_probe_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [10:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_mode = '0;
    logic [SW-1:0] i_slot = '0;
    logic [PW-1:0] i_position = '0;
    logic [7:0] i_byte_value = '0;
    logic i_used_value = 1'b0;
    logic i_last = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [1:0] o_status;
    logic [SW-1:0] o_result_slot;

    double_hash_word_probe i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_mode(i_mode), .i_slot(i_slot), .i_position(i_position),
        .i_byte_value(i_byte_value), .i_used_value(i_used_value), .i_last(i_last),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_status(o_status), .o_result_slot(o_result_slot)
    );

    always #6 i_clk = ~i_clk;

    // table model, updated on accepted words
    logic [7:0]  tbl_word [0:NB-1][0:WB-1];
    logic        tbl_used [0:NB-1];
    logic [7:0]  qry_buf [0:WB-1];
    int unsigned qry_len;
    logic [31:0] qry_hash;
    logic [10:0] bucket_reg;
    t_probe_res  pending_probes[$];
    int          n_errors = 0;

    // generator view of the table, used to keep every probed word readable
    logic [7:0]  gen_word [0:NB-1][0:WB-1];
    bit          gen_wr   [0:NB-1][0:WB-1];
    bit          gen_used [0:NB-1];
    logic [7:0]  word_buf[$];
    int          items_sent = 0;
    int          burst_left = 0;
    bit          hold_req = 0;
    int          hold_cnt = 0;
    int          rx_cycle = 0;
    int          cycles = 0;

    function automatic int unsigned eff_buckets(logic [10:0] r);
        if (r < 2) return 2;
        if (r > NB) return NB;
        return 32'(r);
    endfunction

    function automatic bit slot_holds_query(int unsigned s);
        logic [7:0] st, q;
        for (int i = 0; i < WB; i++) begin
            st = tbl_word[s][i];
            q = (i < qry_len) ? qry_buf[i] : 8'd0;
            if (st != q) return 0;
            if (st == 8'd0) return 1;
        end
        return qry_len == WB;
    endfunction

    function automatic t_probe_res run_probe();
        int unsigned n, h, stride;
        t_probe_res r;
        n = eff_buckets(bucket_reg);
        h = qry_hash % n;
        stride = 1 + (qry_hash % (n - 1));
        r.status = dhwp_pkg::STATUS_FULL;
        r.slot = '0;
        for (int i = 0; i < n; i++) begin
            if (!tbl_used[h]) begin
                r.status = dhwp_pkg::STATUS_EMPTY;
                r.slot = SW'(h);
                return r;
            end
            if (slot_holds_query(h)) begin
                r.status = dhwp_pkg::STATUS_MATCH;
                r.slot = SW'(h);
                return r;
            end
            h += stride;
            if (h >= n) h -= n;
        end
        return r;
    endfunction

    task automatic absorb_word();
        if (i_mode == dhwp_pkg::MODE_WORD) begin
            tbl_word[i_slot][i_position] = i_byte_value;
        end else if (i_mode == dhwp_pkg::MODE_USED) begin
            tbl_used[i_slot] = i_used_value;
        end else if (i_mode == dhwp_pkg::MODE_QUERY) begin
            if (i_byte_value != 8'd0) begin
                qry_hash = qry_hash * 32'd33 + {{24{i_byte_value[7]}}, i_byte_value};
                if (qry_len < WB) qry_buf[qry_len] = i_byte_value;
                if (qry_len <= WB) qry_len++;
            end
            if (i_last) begin
                pending_probes = {pending_probes, run_probe()};
                qry_len = 0;
                qry_hash = '0;
            end
        end
    endtask

    // monitor: check results, then fold in accepted words and config writes
    always @(posedge i_clk) begin
        t_probe_res want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_probes.size() == 0) begin
                    $display("%0t: unexpected result status=%0d slot=%0d",
                             $time, o_status, o_result_slot);
                    n_errors++;
                end else begin
                    want = pending_probes.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_status);
                        n_errors++;
                    end
                    if (o_result_slot !== want.slot) begin
                        $display("%0t: result_slot expected %0d actual %0d",
                                 $time, want.slot, o_result_slot);
                        n_errors++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) absorb_word();
            if (i_cfg_we) bucket_reg = i_cfg_data;
        end
    end

    // receiver: rotating stall pattern, plus a long hold-off on request
    always @(negedge i_clk) begin
        rx_cycle++;
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_cnt = 3000;
            i_out_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 300) % 3)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= ($urandom_range(0, 1) == 0);
                default: i_out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] m, logic [SW-1:0] s, logic [PW-1:0] p,
                             logic [7:0] b, logic uv, logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_mode <= m;
        i_slot <= s;
        i_position <= p;
        i_byte_value <= b;
        i_used_value <= uv;
        i_last <= lst;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic put_byte(int s, int p, logic [7:0] b);
        gen_word[s][p] = b;
        gen_wr[s][p] = 1;
        send_item(dhwp_pkg::MODE_WORD, SW'(s), PW'(p), b, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    function automatic bit readable(int s);
        for (int i = 0; i < WB; i++) begin
            if (!gen_wr[s][i]) return 0;
            if (gen_word[s][i] == 8'd0) return 1;
        end
        return 1;
    endfunction

    task automatic set_used(int s, bit v);
        if (v && !readable(s)) return;
        gen_used[s] = v;
        send_item(dhwp_pkg::MODE_USED, SW'(s), PW'($urandom), 8'($urandom), v,
                  1'($urandom_range(0, 1)));
    endtask

    task automatic store_word(int s);
        for (int i = 0; i < word_buf.size() && i < WB; i++)
            put_byte(s, i, word_buf[i]);
        if (word_buf.size() < WB) put_byte(s, word_buf.size(), 8'd0);
        set_used(s, 1);
    endtask

    task automatic ask(logic [7:0] tail);
        int n;
        n = word_buf.size();
        if (n == 0) begin
            send_item(dhwp_pkg::MODE_QUERY, SW'($urandom), PW'($urandom), tail,
                      1'($urandom_range(0, 1)), 1'b1);
        end else begin
            for (int i = 0; i < n; i++)
                send_item(dhwp_pkg::MODE_QUERY, SW'($urandom), PW'($urandom), word_buf[i],
                          1'($urandom_range(0, 1)), i == n - 1);
        end
    endtask

    task automatic rand_word(int len);
        word_buf.delete();
        repeat (len) word_buf = {word_buf, 8'($urandom_range(1, 255))};
    endtask

    task automatic word_of(int s);
        word_buf.delete();
        for (int i = 0; i < WB; i++) begin
            if (gen_word[s][i] == 8'd0) break;
            word_buf = {word_buf, gen_word[s][i]};
        end
    endtask

    // hold input low until every result is back and the block is quiet
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_probes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_buckets(logic [10:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_extremes();
        word_buf = '{8'hFF, 8'h80, 8'h7F, 8'h01};
        store_word(1023);
        ask(8'd0);
        rand_word(WB);   // word filling the slot, no terminator
        store_word(0);
        ask(8'd0);
        word_buf = {word_buf, 8'h41};   // one byte too long
        ask(8'd0);
        set_used(1023, 0);
        word_buf = '{8'hFF, 8'h80, 8'h7F, 8'h01};
        ask(8'd0);
    endtask

    task automatic test_special_cases();
        send_item(MODE_NONE, 10'h3FF, 6'h3F, 8'hFF, 1'b1, 1'b1);
        word_buf = '{8'h61, 8'h62};
        store_word(517);
        // zero byte inside a query is skipped
        send_item(dhwp_pkg::MODE_QUERY, '0, '0, 8'h61, 1'b0, 1'b0);
        send_item(dhwp_pkg::MODE_QUERY, '0, '0, 8'h00, 1'b0, 1'b0);
        send_item(dhwp_pkg::MODE_QUERY, '0, '0, 8'h62, 1'b0, 1'b1);
        // lone zero byte with last probes an empty word
        word_buf.delete();
        ask(8'd0);
    endtask

    task automatic test_full_table();
        set_buckets(11'd2);
        word_buf = '{8'h10};
        store_word(0);
        word_buf = '{8'h20};
        store_word(1);
        rand_word(3);
        ask(8'd0);
        set_buckets(11'd0);
        ask(8'd0);
        set_buckets(11'd1);
        word_of(1);
        ask(8'd0);
        set_buckets(11'd2047);
        ask(8'd0);
        set_buckets(11'd1024);
    endtask

    task automatic test_random();
        logic [10:0] picks[$] = '{2, 3, 5, 16, 100, 1023, 1024, 0, 1, 2047, 7};
        logic [10:0] pick;
        int n, s, r, tries, phase;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                               : picks[$urandom_range(0, picks.size() - 1)];
            set_buckets(pick);
            n = eff_buckets(pick);
            if (n <= 8 && $urandom_range(0, 1)) begin
                for (int i = 0; i < n; i++) begin
                    rand_word($urandom_range(1, 4));
                    store_word(i);
                end
            end
            if (phase == 3) hold_req = 1;
            repeat (30) begin
                r = $urandom_range(0, 99);
                s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NB - 1)
                                                : $urandom_range(0, n - 1);
                if (r < 15) begin
                    rand_word(($urandom_range(0, 9) == 0) ? $urandom_range(0, 64)
                                                          : $urandom_range(1, 8));
                    store_word(s);
                end else if (r < 55) begin
                    tries = 0;
                    while (!gen_used[s] && tries < 8) begin
                        s = $urandom_range(0, n - 1);
                        tries++;
                    end
                    if (gen_used[s]) word_of(s);
                    else rand_word($urandom_range(1, 6));
                    ask(8'd0);
                end else if (r < 75) begin
                    rand_word(($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                           : $urandom_range(0, 8));
                    if (word_buf.size() > 2 && $urandom_range(0, 3) == 0)
                        word_buf[1] = 8'd0;
                    ask(8'd0);
                end else if (r < 85) begin
                    set_used(s, 1'($urandom_range(0, 1)));
                end else if (r < 95) begin
                    if (!gen_used[s]) put_byte(s, $urandom_range(0, 63), 8'($urandom));
                end else begin
                    send_item(MODE_NONE, SW'($urandom), PW'($urandom), 8'($urandom),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            phase++;
        end
    endtask

    initial begin
        for (int s = 0; s < NB; s++) begin
            tbl_used[s] = 0;
            gen_used[s] = 0;
            for (int i = 0; i < WB; i++) begin
                tbl_word[s][i] = 8'd0;
                gen_word[s][i] = 8'd0;
                gen_wr[s][i] = 0;
            end
        end
        for (int i = 0; i < WB; i++) qry_buf[i] = 8'd0;
        qry_len = 0;
        qry_hash = '0;
        bucket_reg = 11'd1024;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_special_cases();
        test_full_table();
        test_random();

        drain();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && pending_probes.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
